FILE: hw/rtl/kbe_pkg.sv
// ----------------------------------------------------------------------------
// kbe_pkg
// Shared constants and types for the keyboard report to matrix event block.
// ----------------------------------------------------------------------------
`default_nettype none

package kbe_pkg;

  // Geometry of the emulated matrix and of the chord table.
  localparam int MATRIX_ROWS     = 7;
  localparam int MAX_NEW_PRESSES = 6;
  localparam int CHORD_SLOTS     = 4;

  localparam int CHORD_DEPTH = 2048 * CHORD_SLOTS;
  localparam int CHORD_AW    = $clog2(CHORD_DEPTH);
  localparam int SLOTC_W     = $clog2(CHORD_SLOTS + 1);
  localparam int CNT_W       = $clog2(MAX_NEW_PRESSES + 1);
  localparam int ROW_W       = 3;

  // Command codes of an input word.
  localparam logic [1:0] CMD_REPORT = 2'd0;
  localparam logic [1:0] CMD_DIRECT = 2'd1;
  localparam logic [1:0] CMD_CHORD  = 2'd2;

  // Result kinds.
  localparam logic EV_SWITCH = 1'b0;
  localparam logic EV_PAUSE  = 1'b1;

  // Table entry with the skip bit set.
  localparam logic [6:0] ENTRY_SKIP = 7'h40;
  localparam logic [7:0] KEY_Z      = 8'h1d;

  // One result word.
  typedef struct packed {
    logic       kind;
    logic [2:0] row;
    logic [2:0] col;
    logic       closed;
    logic       mapped;
    logic       last;
  } ev_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kbe_if.sv
// ----------------------------------------------------------------------------
// kbe_in_if / kbe_out_if
// Valid/ready channels for report words and for switch event words.
// ----------------------------------------------------------------------------
`default_nettype none

interface kbe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  modifier_bits;
  logic [7:0]  key_code_0;
  logic [7:0]  key_code_1;
  logic [7:0]  key_code_2;
  logic [7:0]  key_code_3;
  logic [7:0]  key_code_4;
  logic [7:0]  key_code_5;
  logic [12:0] table_index;
  logic [6:0]  table_data;

  modport source (output valid, command, modifier_bits, key_code_0, key_code_1,
                  key_code_2, key_code_3, key_code_4, key_code_5, table_index,
                  table_data, input ready);
  modport sink (input valid, command, modifier_bits, key_code_0, key_code_1,
                key_code_2, key_code_3, key_code_4, key_code_5, table_index,
                table_data, output ready);
endinterface

interface kbe_out_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [2:0] switch_row;
  logic [2:0] switch_col;
  logic       switch_closed;
  logic       mode_is_mapped;
  logic       last_event;

  modport source (output valid, event_kind, switch_row, switch_col, switch_closed,
                  mode_is_mapped, last_event, input ready);
  modport sink (input valid, event_kind, switch_row, switch_col, switch_closed,
                mode_is_mapped, last_event, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/keyboard_report_to_matrix_events.sv
// ----------------------------------------------------------------------------
// keyboard_report_to_matrix_events
// Turns boot-keyboard reports into crosspoint switch writes and pause events.
// ----------------------------------------------------------------------------
// One word is handled at a time; the input is ready only while the sequencer
// is idle. A table write is done in the idle state that accepts it. A report
// passes the idle state that accepts it, a decision state and a finishing
// state plus, in direct mode, a table read and an accumulate step per nonzero
// keycode, a skip step per empty keycode slot and, for each of the MATRIX_ROWS
// rows, a compare step and its release and press events; in mapped mode a scan
// of the key-map rows plus, per new press, the chord slots read for closing,
// a pause and the slots read again for opening, from a registered-read memory.
// A stalled output holds the sequencer. After reset the CHORD_DEPTH (8192)
// chord table entries are cleared to skip; no word is accepted until that ends.
// The last result of a report is held back one slot to carry last_event.
`default_nettype none

module keyboard_report_to_matrix_events
  import kbe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  kbe_in_if.sink    in_chan,
  kbe_out_if.source out_chan
);

  // Sequencer codes.
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_DKEY   = 4'd3;
  localparam logic [3:0] S_DACC   = 4'd4;
  localparam logic [3:0] S_DROW   = 4'd5;
  localparam logic [3:0] S_DREL   = 4'd6;
  localparam logic [3:0] S_DPRS   = 4'd7;
  localparam logic [3:0] S_MSCAN  = 4'd8;
  localparam logic [3:0] S_MRD    = 4'd9;
  localparam logic [3:0] S_MEMIT  = 4'd10;
  localparam logic [3:0] S_MPAUSE = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;

  // Table memories.
  logic [6:0] dmem [256];
  logic [255:0] dvld_r;
  logic [6:0] dq_r;
  logic       dvq_r;
  logic [6:0] cmem [CHORD_DEPTH];
  logic [6:0] cq_r;

  logic         dre, dwe, cre, cwe;
  logic [7:0]   dra, dwa;
  logic [CHORD_AW-1:0] cra, cwa;
  logic [6:0]   dwd, cwd;

  // Sequencer state.
  logic [3:0]  state_r, state_nxt;
  logic [CHORD_AW-1:0] clr_r, clr_nxt;
  logic [7:0]  mods_r, mods_nxt;
  logic [7:0]  kc_r [6];
  logic [7:0]  kc_nxt [6];
  logic [15:0] prev_map_r [16];
  logic [15:0] prev_map_nxt [16];
  logic [15:0] press_r [16];
  logic [15:0] press_nxt [16];
  logic        gui_r, gui_nxt;
  logic        mapped_r, mapped_nxt;
  logic [7:0]  prev_mat_r [MATRIX_ROWS];
  logic [7:0]  prev_mat_nxt [MATRIX_ROWS];
  logic [7:0]  cur_mat_r [MATRIX_ROWS];
  logic [7:0]  cur_mat_nxt [MATRIX_ROWS];
  logic [2:0]  ki_r, ki_nxt;
  logic [ROW_W-1:0] mrow_r, mrow_nxt;
  logic [7:0]  rel_r, rel_nxt, prs_r, prs_nxt;
  logic [3:0]  srow_r, srow_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [7:0]  key_r, key_nxt;
  logic [SLOTC_W-1:0] slot_r, slot_nxt;
  logic        open_r, open_nxt;

  // Held-back event and output register.
  logic pend_v_r, pend_v_nxt;
  ev_t  pend_r, pend_nxt;
  logic out_v_r, out_v_nxt;
  ev_t  out_r, out_nxt;

  logic gen, go, fin_push;
  ev_t  gen_ev;

  logic [15:0] cur_map [16];
  logic [2:0]  ms;
  logic        in_acc;

  function automatic logic [2:0] lsb8(input logic [7:0] v);
    logic [2:0] p;
    p = '0;
    for (int b = 7; b >= 0; b--) begin
      if (v[b]) p = 3'(b);
    end
    return p;
  endfunction

  function automatic logic [3:0] lsb16(input logic [15:0] v);
    logic [3:0] p;
    p = '0;
    for (int b = 15; b >= 0; b--) begin
      if (v[b]) p = 4'(b);
    end
    return p;
  endfunction

  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);

  // Current key map from the latched report.
  always_comb begin
    for (int r = 0; r < 16; r++) cur_map[r] = '0;
    cur_map[14] = {12'd0, mods_r[3:0]};
    for (int i = 0; i < 6; i++) begin
      if (kc_r[i] != 8'd0) cur_map[kc_r[i][7:4]][kc_r[i][3:0]] = 1'b1;
    end
  end

  assign ms = {|(mods_r & 8'h44), |(mods_r & 8'h22), |(mods_r & 8'h11)};

  // An event may be produced unless the held one cannot move on.
  assign go = !pend_v_r || !out_v_r || out_chan.ready;

  // Table memories: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (dwe) dmem[dwa] <= dwd;
    if (dre) dq_r <= dmem[dra];
    if (cwe) cmem[cwa] <= cwd;
    if (cre) cq_r <= cmem[cra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r <= '0;
    end else if (dwe) begin
      dvld_r[dwa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dre) dvq_r <= dvld_r[dra];
  end

  // Sequencer.
  always_comb begin
    logic [15:0] prs14, rel14;
    logic [6:0]  e;
    logic [3:0]  b;
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    mods_nxt     = mods_r;
    kc_nxt       = kc_r;
    prev_map_nxt = prev_map_r;
    press_nxt    = press_r;
    gui_nxt      = gui_r;
    mapped_nxt   = mapped_r;
    prev_mat_nxt = prev_mat_r;
    cur_mat_nxt  = cur_mat_r;
    ki_nxt       = ki_r;
    mrow_nxt     = mrow_r;
    rel_nxt      = rel_r;
    prs_nxt      = prs_r;
    srow_nxt     = srow_r;
    n_nxt        = n_r;
    key_nxt      = key_r;
    slot_nxt     = slot_r;
    open_nxt     = open_r;
    gen          = 1'b0;
    gen_ev       = '0;
    fin_push     = 1'b0;
    dre = 1'b0; dwe = 1'b0; cre = 1'b0; cwe = 1'b0;
    dra = kc_r[ki_r];
    dwa = in_chan.table_index[7:0];
    dwd = in_chan.table_data;
    cra = CHORD_AW'(({3'd0, key_r, 3'd0} + {11'd0, ms}) * 14'(CHORD_SLOTS))
          + CHORD_AW'(slot_r);
    cwa = in_chan.table_index[CHORD_AW-1:0];
    cwd = in_chan.table_data;
    prs14 = ~prev_map_r[14] & cur_map[14];
    rel14 = prev_map_r[14] & ~cur_map[14];
    e = '0;
    b = '0;

    unique case (state_r)
      S_CLEAR: begin
        cwe = 1'b1;
        cwa = clr_r;
        cwd = ENTRY_SKIP;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CHORD_AW'(CHORD_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          mods_nxt  = in_chan.modifier_bits;
          kc_nxt[0] = in_chan.key_code_0;
          kc_nxt[1] = in_chan.key_code_1;
          kc_nxt[2] = in_chan.key_code_2;
          kc_nxt[3] = in_chan.key_code_3;
          kc_nxt[4] = in_chan.key_code_4;
          kc_nxt[5] = in_chan.key_code_5;
          priority if (in_chan.command == CMD_REPORT) begin
            state_nxt = S_DECIDE;
          end else if (in_chan.command == CMD_DIRECT) begin
            dwe = (in_chan.table_index < 13'd256);
          end else if (in_chan.command == CMD_CHORD) begin
            cwe = ({1'b0, in_chan.table_index} < 14'(CHORD_DEPTH));
          end else begin
            // The unused command is dropped without any effect.
            state_nxt = S_IDLE;
          end
        end
      end
      S_DECIDE: begin
        for (int r = 0; r < 16; r++) begin
          prev_map_nxt[r] = cur_map[r];
          press_nxt[r]    = ~prev_map_r[r] & cur_map[r];
        end
        gui_nxt = gui_r;
        if ((prs14 & 16'h0088) != 16'd0) gui_nxt = 1'b1;
        if ((rel14 & 16'h0088) != 16'd0) gui_nxt = 1'b0;
        if (gui_nxt) begin
          if (~prev_map_r[KEY_Z[7:4]][KEY_Z[3:0]] & cur_map[KEY_Z[7:4]][KEY_Z[3:0]])
            mapped_nxt = !mapped_r;
          state_nxt = S_FIN;
        end else if (mapped_r) begin
          srow_nxt  = '0;
          n_nxt     = '0;
          state_nxt = S_MSCAN;
        end else begin
          for (int r = 0; r < MATRIX_ROWS; r++) cur_mat_nxt[r] = '0;
          cur_mat_nxt[MATRIX_ROWS-1] = {|(mods_r & 8'h22), 2'b00, |(mods_r & 8'h11),
                                        |(mods_r & 8'h44), 3'b000};
          ki_nxt    = '0;
          state_nxt = S_DKEY;
        end
      end
      S_DKEY: begin
        if (kc_r[ki_r] != 8'd0) begin
          dre       = 1'b1;
          state_nxt = S_DACC;
        end else if (ki_r == 3'd5) begin
          mrow_nxt  = '0;
          state_nxt = S_DROW;
        end else begin
          ki_nxt = ki_r + 3'd1;
        end
      end
      S_DACC: begin
        e = dvq_r ? dq_r : ENTRY_SKIP;
        if (!e[6] && ({1'b0, e[5:3]} < 4'(MATRIX_ROWS)))
          cur_mat_nxt[e[5:3]][e[2:0]] = 1'b1;
        if (ki_r == 3'd5) begin
          mrow_nxt  = '0;
          state_nxt = S_DROW;
        end else begin
          ki_nxt    = ki_r + 3'd1;
          state_nxt = S_DKEY;
        end
      end
      S_DROW: begin
        rel_nxt = prev_mat_r[mrow_r] & ~cur_mat_r[mrow_r];
        prs_nxt = ~prev_mat_r[mrow_r] & cur_mat_r[mrow_r];
        prev_mat_nxt[mrow_r] = cur_mat_r[mrow_r];
        state_nxt = S_DREL;
      end
      S_DREL: begin
        if (rel_r != 8'd0) begin
          gen = 1'b1;
          gen_ev = '{kind: EV_SWITCH, row: mrow_r, col: lsb8(rel_r), closed: 1'b0,
                     mapped: mapped_r, last: 1'b0};
          if (go) rel_nxt[lsb8(rel_r)] = 1'b0;
        end else begin
          state_nxt = S_DPRS;
        end
      end
      S_DPRS: begin
        if (prs_r != 8'd0) begin
          gen = 1'b1;
          gen_ev = '{kind: EV_SWITCH, row: mrow_r, col: lsb8(prs_r), closed: 1'b1,
                     mapped: mapped_r, last: 1'b0};
          if (go) prs_nxt[lsb8(prs_r)] = 1'b0;
        end else if (mrow_r == ROW_W'(MATRIX_ROWS - 1)) begin
          state_nxt = S_FIN;
        end else begin
          mrow_nxt  = mrow_r + 1'b1;
          state_nxt = S_DROW;
        end
      end
      S_MSCAN: begin
        if (press_r[srow_r] != 16'd0) begin
          b = lsb16(press_r[srow_r]);
          press_nxt[srow_r][b] = 1'b0;
          key_nxt   = {srow_r, b};
          n_nxt     = n_r + 1'b1;
          slot_nxt  = '0;
          open_nxt  = 1'b0;
          state_nxt = S_MRD;
        end else if (srow_r == 4'd15) begin
          state_nxt = S_FIN;
        end else begin
          srow_nxt = srow_r + 4'd1;
        end
      end
      S_MRD: begin
        if (slot_r == SLOTC_W'(CHORD_SLOTS)) begin
          if (!open_r) state_nxt = S_MPAUSE;
          else if (n_r == CNT_W'(MAX_NEW_PRESSES)) state_nxt = S_FIN;
          else state_nxt = S_MSCAN;
        end else begin
          cre       = 1'b1;
          state_nxt = S_MEMIT;
        end
      end
      S_MEMIT: begin
        if (cq_r[6]) begin
          slot_nxt  = slot_r + 1'b1;
          state_nxt = S_MRD;
        end else begin
          gen = 1'b1;
          gen_ev = '{kind: EV_SWITCH, row: cq_r[5:3], col: cq_r[2:0], closed: !open_r,
                     mapped: mapped_r, last: 1'b0};
          if (go) begin
            slot_nxt  = slot_r + 1'b1;
            state_nxt = S_MRD;
          end
        end
      end
      S_MPAUSE: begin
        gen = 1'b1;
        gen_ev = '{kind: EV_PAUSE, row: 3'd0, col: 3'd0, closed: 1'b0,
                   mapped: mapped_r, last: 1'b0};
        if (go) begin
          open_nxt  = 1'b1;
          slot_nxt  = '0;
          state_nxt = S_MRD;
        end
      end
      S_FIN: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (!out_v_r || out_chan.ready) begin
          fin_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Held-back slot and output register.
  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r && !out_chan.ready;
    out_nxt    = out_r;
    if (gen && go) begin
      pend_v_nxt = 1'b1;
      pend_nxt   = gen_ev;
      if (pend_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = pend_r;
      end
    end else if (fin_push) begin
      pend_v_nxt    = 1'b0;
      out_v_nxt     = 1'b1;
      out_nxt       = pend_r;
      out_nxt.last  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      gui_r    <= 1'b0;
      mapped_r <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      for (int r = 0; r < 16; r++) prev_map_r[r] <= '0;
      for (int r = 0; r < MATRIX_ROWS; r++) prev_mat_r[r] <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      gui_r      <= gui_nxt;
      mapped_r   <= mapped_nxt;
      pend_v_r   <= pend_v_nxt;
      out_v_r    <= out_v_nxt;
      prev_map_r <= prev_map_nxt;
      prev_mat_r <= prev_mat_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    mods_r    <= mods_nxt;
    kc_r      <= kc_nxt;
    press_r   <= press_nxt;
    cur_mat_r <= cur_mat_nxt;
    ki_r      <= ki_nxt;
    mrow_r    <= mrow_nxt;
    rel_r     <= rel_nxt;
    prs_r     <= prs_nxt;
    srow_r    <= srow_nxt;
    n_r       <= n_nxt;
    key_r     <= key_nxt;
    slot_r    <= slot_nxt;
    open_r    <= open_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
  end

  assign out_chan.valid          = out_v_r;
  assign out_chan.event_kind     = out_r.kind;
  assign out_chan.switch_row     = out_r.row;
  assign out_chan.switch_col     = out_r.col;
  assign out_chan.switch_closed  = out_r.closed;
  assign out_chan.mode_is_mapped = out_r.mapped;
  assign out_chan.last_event     = out_r.last;

endmodule

`default_nettype wire
